### rtl/kdar_pkg.sv
// Shared widths, register indexes and the configuration bundle for the key debouncer.
package kdar_pkg;

  localparam int unsigned KEY_W   = 5;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_ACTIVE_LEVEL      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ALLOW_MULTI       = 3'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT_ENABLE     = 3'd2;
  localparam logic [IDX_W-1:0] REG_REPEAT_ACCELERATE = 3'd3;
  localparam logic [IDX_W-1:0] REG_FIRST_DELAY       = 3'd4;
  localparam logic [IDX_W-1:0] REG_REPEAT_DELAY      = 3'd5;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd100;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd20;

  typedef struct packed {
    logic               active_level;
    logic               allow_multi;
    logic               repeat_enable;
    logic               repeat_accelerate;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] repeat_delay;
  } cfg_t;

endpackage

### rtl/kdar_cfg_regs.sv
// APB-style configuration register file for the key debouncer.
module kdar_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdar_pkg::ADDR_W-1:0]   paddr,
  input  logic [kdar_pkg::DATA_W-1:0]   pwdata,
  output logic [kdar_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output kdar_pkg::cfg_t                cfg
);
  import kdar_pkg::*;

  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level      <= 1'b0;
      cfg.allow_multi       <= 1'b0;
      cfg.repeat_enable     <= 1'b1;
      cfg.repeat_accelerate <= 1'b1;
      cfg.first_delay       <= FIRST_DELAY_RST;
      cfg.repeat_delay      <= REPEAT_DELAY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACTIVE_LEVEL:      cfg.active_level      <= pwdata[0];
        REG_ALLOW_MULTI:       cfg.allow_multi       <= pwdata[0];
        REG_REPEAT_ENABLE:     cfg.repeat_enable     <= pwdata[0];
        REG_REPEAT_ACCELERATE: cfg.repeat_accelerate <= pwdata[0];
        REG_FIRST_DELAY:       cfg.first_delay       <= pwdata[DELAY_W-1:0];
        REG_REPEAT_DELAY:      cfg.repeat_delay      <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ACTIVE_LEVEL:      prdata[0] = cfg.active_level;
      REG_ALLOW_MULTI:       prdata[0] = cfg.allow_multi;
      REG_REPEAT_ENABLE:     prdata[0] = cfg.repeat_enable;
      REG_REPEAT_ACCELERATE: prdata[0] = cfg.repeat_accelerate;
      REG_FIRST_DELAY:       prdata[DELAY_W-1:0] = cfg.first_delay;
      REG_REPEAT_DELAY:      prdata[DELAY_W-1:0] = cfg.repeat_delay;
      default:               prdata = '0;
    endcase
  end

endmodule

### rtl/kdar_decide.sv
// Debounce decision logic and the held-key state it updates once per scan tick.
module kdar_decide #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  kdar_pkg::cfg_t              cfg,
  input  logic [kdar_pkg::KEY_W-1:0]  first_sample,
  input  logic [kdar_pkg::KEY_W-1:0]  second_sample,
  output logic [kdar_pkg::KEY_W-1:0]  key_code
);
  import kdar_pkg::*;

  logic [KEY_W-1:0]   key_mask;
  logic [KEY_W-1:0]   mask_a;
  logic [KEY_W-1:0]   mask_b;
  logic               single_key;
  logic [DELAY_W-1:0] hold_inc;
  logic [DELAY_W-1:0] limit;

  logic [KEY_W-1:0]   last_mask;
  logic [KEY_W-1:0]   last_mask_next;
  logic [DELAY_W-1:0] hold_count;
  logic [DELAY_W-1:0] hold_count_next;
  logic               repeat_phase;
  logic               repeat_phase_next;

  // Pins at or above NUM_KEYS never count as pressed.
  always_comb begin
    for (int i = 0; i < KEY_W; i++) begin
      key_mask[i] = (i < NUM_KEYS);
    end
  end

  assign mask_a     = (cfg.active_level ? first_sample  : ~first_sample)  & key_mask;
  assign mask_b     = (cfg.active_level ? second_sample : ~second_sample) & key_mask;
  assign single_key = (mask_a != '0) && ((mask_a & (mask_a - 1'b1)) == '0);
  assign hold_inc   = hold_count + 1'b1;
  assign limit      = repeat_phase ? cfg.repeat_delay : cfg.first_delay;

  always_comb begin
    last_mask_next    = last_mask;
    hold_count_next   = hold_count;
    repeat_phase_next = repeat_phase;
    key_code          = '0;
    priority if (mask_a != mask_b) begin
      hold_count_next = '0;
    end else if (mask_a == '0) begin
      last_mask_next    = '0;
      hold_count_next   = '0;
      repeat_phase_next = 1'b0;
    end else if (mask_a != last_mask) begin
      hold_count_next = '0;
      last_mask_next  = mask_a;
      if (cfg.allow_multi || single_key) begin
        key_code = mask_a;
      end
    end else if (!cfg.allow_multi && !single_key) begin
      hold_count_next = '0;
    end else if (!cfg.repeat_enable) begin
      hold_count_next = '0;
    end else if (hold_inc > limit) begin
      hold_count_next = '0;
      key_code        = mask_a;
      if (cfg.repeat_accelerate) begin
        repeat_phase_next = 1'b1;
      end
    end else begin
      hold_count_next = hold_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_mask    <= '0;
      hold_count   <= '0;
      repeat_phase <= 1'b0;
    end else if (step) begin
      last_mask    <= last_mask_next;
      hold_count   <= hold_count_next;
      repeat_phase <= repeat_phase_next;
    end
  end

endmodule

### rtl/key_debounce_auto_repeat_core.sv
// Key debouncer with auto-repeat: input register, decision logic and result register.
// Each scan tick is one transfer of two pin samples and yields one transfer of key_code,
// where zero means no event. The block takes one tick per clock cycle unless in_stall is
// high. An accepted tick waits in the input register, moves into the result register when
// that is empty or being emptied, and is offered as a result from there.
// While a result waits to be taken, the input register holds one more tick and then the
// input stalls until the result is taken.
// Configuration registers sit on an APB-style port at byte addresses 0 to 20.
module key_debounce_auto_repeat_core #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdar_pkg::ADDR_W-1:0]   paddr,
  input  logic [kdar_pkg::DATA_W-1:0]   pwdata,
  output logic [kdar_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kdar_pkg::KEY_W-1:0]    first_sample,
  input  logic [kdar_pkg::KEY_W-1:0]    second_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kdar_pkg::KEY_W-1:0]    key_code
);
  import kdar_pkg::*;

  cfg_t             cfg;
  logic             in_full;
  logic [KEY_W-1:0] first_q;
  logic [KEY_W-1:0] second_q;
  logic             out_full;
  logic             advance;
  logic [KEY_W-1:0] code;

  kdar_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kdar_decide #(
    .NUM_KEYS (NUM_KEYS)
  ) u_decide (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .cfg           (cfg),
    .first_sample  (first_q),
    .second_sample (second_q),
    .key_code      (code)
  );

  // The held tick moves on whenever the result register is empty or being emptied.
  assign advance   = in_full && (!out_full || !out_stall);
  assign in_stall  = in_full && !advance;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      first_q  <= first_sample;
      second_q <= second_sample;
    end
    if (advance) begin
      key_code <= code;
    end
  end

endmodule
